// File: sv/vrp_pkg.sv
// ----------------------------------------------------------------------------
// vrp_pkg
// Shared types, constants and trig helpers for the vertex projection unit.
// ----------------------------------------------------------------------------
package vrp_pkg;

  localparam int ANGLE_BITS  = 10;
  localparam int FRAC_BITS   = 12;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int TRIG_W      = 14;  // signed sine/cosine, 1.0 = 4096
  localparam int ROT_W       = 19;  // rotated coordinate after the 1/4096 scale
  localparam int DEN_W       = 20;  // signed depth
  localparam int NUM_W       = 32;  // signed projection numerator
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEPTH_OFFSET = 2'd0,
    REG_PIXEL_SCALE  = 2'd1,
    REG_CENTER_X     = 2'd2,
    REG_CENTER_Y     = 2'd3
  } vrp_reg_t;

  typedef struct packed {
    logic signed [15:0]      vertex_x;
    logic signed [15:0]      vertex_y;
    logic signed [15:0]      vertex_z;
    logic [ANGLE_BITS-1:0]   rotation_angle;
  } vrp_in_t;

  typedef struct packed {
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic               depth_clamped;
  } vrp_out_t;

  typedef struct packed {
    logic signed [15:0] depth_offset;
    logic [7:0]         pixel_scale;
    logic [9:0]         center_x;
    logic [9:0]         center_y;
  } vrp_cfg_t;

  // one projection job handed from the front end to the divider
  typedef struct packed {
    logic signed [NUM_W-1:0] num_x;
    logic signed [NUM_W-1:0] num_y;
    logic signed [DEN_W-1:0] den;
    logic                    clamped;
  } vrp_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } vrp_qstat_t;

  localparam logic [12:0] QSINE [17] = '{
    13'd0,    13'd401,  13'd799,  13'd1189, 13'd1567, 13'd1931,
    13'd2276, 13'd2598, 13'd2896, 13'd3166, 13'd3406, 13'd3612,
    13'd3784, 13'd3920, 13'd4017, 13'd4076, 13'd4096
  };

  // sine magnitude over a quarter turn, u = 0 .. 16384
  function automatic logic [12:0] quarter_lookup(logic [14:0] u);
    logic [4:0]  idx;
    logic [9:0]  fr;
    logic [12:0] a;
    logic [12:0] b;
    logic [18:0] prod;
    logic [12:0] r;
    idx  = {1'b0, u[13:10]};
    fr   = u[9:0];
    a    = QSINE[idx];
    b    = QSINE[idx + 5'd1];
    prod = {6'b0, 13'(b - a)} * {9'b0, fr};
    r    = a + {4'b0, prod[18:10]};
    if (u[14]) begin
      r = QSINE[16];
    end
    return r;
  endfunction

  function automatic logic signed [TRIG_W-1:0] phase_sine(logic [15:0] ph);
    logic [14:0] q;
    logic [14:0] qr;
    logic [12:0] m;
    q  = {1'b0, ph[13:0]};
    qr = 15'd16384 - q;
    m  = ph[14] ? quarter_lookup(qr) : quarter_lookup(q);
    return ph[15] ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

endpackage

// File: sv/vertex_rotate_project_to_screen.sv
// ----------------------------------------------------------------------------
// vertex_rotate_project_to_screen
// Rotate a vertex about Y, add depth offset, perspective-project to screen.
// ----------------------------------------------------------------------------
//  channel   | signals                        | beat
//  ----------+--------------------------------+-------------------------------
//  input     | in_valid, in_data, in_stall    | one vertex + angle
//  output    | out_valid, out_data, out_stall | pixel_x, pixel_y, clamp flag
//  config    | cfg_we, cfg_index, cfg_data    | one register write
//
// One beat per cycle sustained while no output stall or full queue holds it.
// A beat passes the front stages, the queue, the divider (a sign stage, then
// one quotient bit per stage) and the output register. Reset clears all valid
// bits and loads the register defaults. A stalled valid output freezes the
// divider; the 4-entry queue then fills and the front end stalls the input
// once the queue is full and a job waits at its last stage.
// ----------------------------------------------------------------------------
module vertex_rotate_project_to_screen #(
  parameter int FRAC_BITS = vrp_pkg::FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [vrp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vrp_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            in_valid,
  input  vrp_pkg::vrp_in_t                in_data,
  output logic                            in_stall,
  output logic                            out_valid,
  output vrp_pkg::vrp_out_t               out_data,
  input  logic                            out_stall
);
  import vrp_pkg::*;

  vrp_cfg_t   cfg;
  vrp_job_t   f_job, q_job;
  vrp_qstat_t q_stat;
  logic       f_valid, q_push, q_pop;

  // register file: write-only, loaded with defaults on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.depth_offset <= 16'sd8192;
      cfg.pixel_scale  <= 8'd32;
      cfg.center_x     <= 10'd64;
      cfg.center_y     <= 10'd32;
    end else if (cfg_we) begin
      case (vrp_reg_t'(cfg_index))
        REG_DEPTH_OFFSET: cfg.depth_offset <= cfg_data;
        REG_PIXEL_SCALE:  cfg.pixel_scale  <= cfg_data[7:0];
        REG_CENTER_X:     cfg.center_x     <= cfg_data[9:0];
        REG_CENTER_Y:     cfg.center_y     <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // front: trig, rotation, depth clamp, numerators; hold while queue is full
  vrp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .hold      (q_stat.full),
    .job_valid (f_valid),
    .job       (f_job)
  );

  assign q_push = f_valid && !q_stat.full;

  vrp_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .din  (f_job),
    .pop  (q_pop),
    .dout (q_job),
    .stat (q_stat)
  );

  // back: divide, sign fix, saturate
  vrp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (!q_stat.empty),
    .job       (q_job),
    .job_pop   (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_stat.full))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(q_pop && q_stat.empty))
    else $error("queue pop while empty");

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

// File: sv/vrp_front.sv
// ----------------------------------------------------------------------------
// vrp_front
// Trig lookup, Y rotation, depth offset and clamp, projection numerators.
// ----------------------------------------------------------------------------
module vrp_front #(
  parameter int FRAC_BITS = vrp_pkg::FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  vrp_pkg::vrp_cfg_t cfg,
  input  logic              in_valid,
  input  vrp_pkg::vrp_in_t  in_data,
  output logic              in_stall,
  input  logic              hold,
  output logic              job_valid,
  output vrp_pkg::vrp_job_t job
);
  import vrp_pkg::*;

  localparam int DMIN_RAW  = ((1 << FRAC_BITS) + 500) / 1000;
  localparam int DEPTH_MIN = (DMIN_RAW > 0) ? DMIN_RAW : 1;

  logic en;
  logic [5:0] v;

  // stage 1
  logic signed [15:0]       x1, y1, z1;
  logic signed [TRIG_W-1:0] s1, c1;
  // stage 2
  logic signed [29:0]       p_xc, p_zs, p_xs, p_zc;
  logic signed [15:0]       y2;
  // stage 3
  logic signed [30:0]       sum_x, sum_z;
  logic signed [15:0]       y3;
  // stage 4
  logic signed [ROT_W-1:0]  rx4;
  logic signed [DEN_W-1:0]  d4;
  logic                     cl4;
  logic signed [15:0]       y4;
  // stage 5
  logic signed [30:0]       m_cxd, m_cyd;
  logic signed [27:0]       m_rxs;
  logic signed [24:0]       m_ys;
  logic signed [DEN_W-1:0]  d5;
  logic                     cl5;

  logic [15:0]              phase;
  logic signed [30:0]       bx, bz;
  logic signed [ROT_W-1:0]  rz;
  logic signed [DEN_W-1:0]  draw;

  assign en        = !(v[5] && hold);
  assign in_stall  = !en;
  assign job_valid = v[5];

  assign phase = {in_data.rotation_angle, {(16 - ANGLE_BITS){1'b0}}};
  assign bx    = sum_x + (sum_x[30] ? 31'sd4095 : 31'sd0);
  assign bz    = sum_z + (sum_z[30] ? 31'sd4095 : 31'sd0);
  assign rz    = bz[30:12];
  assign draw  = DEN_W'(rz) + DEN_W'(cfg.depth_offset);

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1    <= in_data.vertex_x;
      y1    <= in_data.vertex_y;
      z1    <= in_data.vertex_z;
      s1    <= phase_sine(phase);
      c1    <= phase_sine(phase + 16'd16384);

      p_xc  <= x1 * c1;
      p_zs  <= z1 * s1;
      p_xs  <= x1 * s1;
      p_zc  <= z1 * c1;
      y2    <= y1;

      sum_x <= 31'(p_xc) - 31'(p_zs);
      sum_z <= 31'(p_xs) + 31'(p_zc);
      y3    <= y2;

      // truncate toward zero, then swap a zero depth for the minimum
      rx4   <= bx[30:12];
      cl4   <= (draw == '0);
      d4    <= (draw == '0) ? DEN_W'(DEPTH_MIN) : draw;
      y4    <= y3;

      m_cxd <= $signed({1'b0, cfg.center_x}) * d4;
      m_cyd <= $signed({1'b0, cfg.center_y}) * d4;
      m_rxs <= rx4 * $signed({1'b0, cfg.pixel_scale});
      m_ys  <= y4 * $signed({1'b0, cfg.pixel_scale});
      d5    <= d4;
      cl5   <= cl4;

      job.num_x   <= NUM_W'(m_cxd) + NUM_W'(m_rxs);
      job.num_y   <= NUM_W'(m_cyd) - NUM_W'(m_ys);
      job.den     <= d5;
      job.clamped <= cl5;
    end
  end

endmodule

// File: sv/vrp_queue.sv
// ----------------------------------------------------------------------------
// vrp_queue
// Small flop FIFO between the front end and the divider back end.
// ----------------------------------------------------------------------------
module vrp_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  vrp_pkg::vrp_job_t   din,
  input  logic                pop,
  output vrp_pkg::vrp_job_t   dout,
  output vrp_pkg::vrp_qstat_t stat
);
  import vrp_pkg::*;

  vrp_job_t          mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;

  assign dout       = mem[rd_ptr];
  assign stat.full  = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

// File: sv/vrp_back.sv
// ----------------------------------------------------------------------------
// vrp_back
// Pipelined signed divider, one quotient bit per stage, then saturation.
// ----------------------------------------------------------------------------
module vrp_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  input  vrp_pkg::vrp_job_t  job,
  output logic               job_pop,
  output logic               out_valid,
  output vrp_pkg::vrp_out_t  out_data,
  input  logic               out_stall
);
  import vrp_pkg::*;

  logic en;

  logic [NUM_W:0]       v;
  logic [NUM_W-1:0]     nq  [NUM_W+1];
  logic [DEN_W-1:0]     rem [NUM_W+1];
  logic [DEN_W-1:0]     dv  [NUM_W+1];
  logic [1:0]           neg [NUM_W+1];  // {x negative, y negative}
  logic [NUM_W-1:0]     qx  [NUM_W+1];
  logic [NUM_W-1:0]     ny  [NUM_W+1];
  logic [DEN_W-1:0]     remy[NUM_W+1];
  logic [NUM_W:0]       cl;

  logic                 dneg;
  logic signed [NUM_W:0] qxs, qys;

  assign en      = !(out_valid && out_stall);
  assign job_pop = en && job_valid;
  assign dneg    = job.den[DEN_W-1];

  // stage 0: take magnitudes and signs
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nq[0]   <= job.num_x[NUM_W-1] ? NUM_W'(-job.num_x) : job.num_x;
      ny[0]   <= job.num_y[NUM_W-1] ? NUM_W'(-job.num_y) : job.num_y;
      dv[0]   <= dneg ? DEN_W'(-job.den) : job.den;
      neg[0]  <= {job.num_x[NUM_W-1] ^ dneg, job.num_y[NUM_W-1] ^ dneg};
      rem[0]  <= '0;
      remy[0] <= '0;
      qx[0]   <= '0;
      cl[0]   <= job.clamped;
    end
  end

  // restoring division, both axes side by side; the y quotient shifts into ny
  for (genvar i = 0; i < NUM_W; i++) begin : g_div
    logic [DEN_W:0] tx, ty;
    logic           gx, gy;
    assign tx = {rem[i], nq[i][NUM_W-1]};
    assign ty = {remy[i], ny[i][NUM_W-1]};
    assign gx = (tx >= {1'b0, dv[i]});
    assign gy = (ty >= {1'b0, dv[i]});

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1]  <= gx ? DEN_W'(tx - {1'b0, dv[i]}) : tx[DEN_W-1:0];
        remy[i+1] <= gy ? DEN_W'(ty - {1'b0, dv[i]}) : ty[DEN_W-1:0];
        nq[i+1]   <= {nq[i][NUM_W-2:0], 1'b0};
        qx[i+1]   <= {qx[i][NUM_W-2:0], gx};
        ny[i+1]   <= {ny[i][NUM_W-2:0], gy};
        dv[i+1]   <= dv[i];
        neg[i+1]  <= neg[i];
        cl[i+1]   <= cl[i];
      end
    end
  end

  function automatic logic signed [15:0] sat16(logic signed [NUM_W:0] a);
    if (a > (NUM_W + 1)'(32767)) begin
      return 16'sh7fff;
    end else if (a < -(NUM_W + 1)'(32768)) begin
      return 16'sh8000;
    end
    return a[15:0];
  endfunction

  assign qxs = neg[NUM_W][1] ? -$signed({1'b0, qx[NUM_W]}) : $signed({1'b0, qx[NUM_W]});
  assign qys = neg[NUM_W][0] ? -$signed({1'b0, ny[NUM_W]}) : $signed({1'b0, ny[NUM_W]});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v[NUM_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.pixel_x       <= sat16(qxs);
      out_data.pixel_y       <= sat16(qys);
      out_data.depth_clamped <= cl[NUM_W];
    end
  end

endmodule

// File: tb/vertex_rotate_project_to_screen_test.sv
// ----------------------------------------------------------------------------
// vertex_rotate_project_to_screen_test
// Drives vertices and angles through the projection unit under random input
// gaps and output stalls, predicts every screen position and checks each
// output beat in order against it. Register settings change between phases.
// ----------------------------------------------------------------------------
module vertex_rotate_project_to_screen_test;
  timeunit 1ns;
  timeprecision 1ps;
  import vrp_pkg::*;

  // Screen-position predictor plus the in-order store of expected beats.
  class projection_board;
    logic signed [15:0] depth_off;
    logic [7:0]         scale;
    logic [9:0]         cx;
    logic [9:0]         cy;
    vrp_out_t           pending[$];
    int                 mismatches;
    int                 reported;

    function void reset_regs();
      depth_off = 16'sd8192;
      scale     = 8'd32;
      cx        = 10'd64;
      cy        = 10'd32;
    endfunction

    function void write_reg(vrp_reg_t idx, logic [15:0] val);
      case (idx)
        REG_DEPTH_OFFSET: depth_off = val;
        REG_PIXEL_SCALE:  scale = val[7:0];
        REG_CENTER_X:     cx = val[9:0];
        REG_CENTER_Y:     cy = val[9:0];
        default: ;
      endcase
    endfunction

    // Quarter-wave sine magnitude, 1.0 = 4096, u in 0..16384.
    function longint wave_mag(int unsigned u);
      int tbl[17] = '{0, 401, 799, 1189, 1567, 1931, 2276, 2598, 2896,
                      3166, 3406, 3612, 3784, 3920, 4017, 4076, 4096};
      int unsigned k;
      int unsigned f;
      if (u >= 16384) return 4096;
      k = u >> 10;
      f = u & 1023;
      return tbl[k] + (((tbl[k+1] - tbl[k]) * f) >> 10);
    endfunction

    function longint phase_sin(int unsigned ph);
      int unsigned q;
      q = ph & 16383;
      case ((ph >> 14) & 3)
        0: return wave_mag(q);
        1: return wave_mag(16384 - q);
        2: return -wave_mag(q);
        default: return -wave_mag(16384 - q);
      endcase
    endfunction

    function longint clip16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function void note_vertex(vrp_in_t v);
      longint x, y, z, s, c, rx, rz, d;
      int unsigned ph;
      vrp_out_t r;
      x  = v.vertex_x;
      y  = v.vertex_y;
      z  = v.vertex_z;
      ph = (int'(v.rotation_angle) << 6) & 16'hFFFF;
      s  = phase_sin(ph);
      c  = phase_sin((ph + 16384) & 16'hFFFF);
      rx = (x * c - z * s) / 4096;
      rz = (x * s + z * c) / 4096;
      d  = rz + longint'(depth_off);
      r.depth_clamped = (d == 0);
      if (d == 0) d = 4;
      r.pixel_x = 16'(clip16((longint'(cx) * d + rx * longint'(scale)) / d));
      r.pixel_y = 16'(clip16((longint'(cy) * d - y * longint'(scale)) / d));
      pending.push_back(r);
    endfunction

    function void check_beat(vrp_out_t got);
      vrp_out_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (reported < 10) begin
          reported++;
          $display("unexpected output beat %h", got);
        end
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (reported < 10) begin
          reported++;
          $display("mismatch: expected x=%0d y=%0d clamp=%0b, got x=%0d y=%0d clamp=%0b",
                   exp_r.pixel_x, exp_r.pixel_y, exp_r.depth_clamped,
                   got.pixel_x, got.pixel_y, got.depth_clamped);
        end
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 400000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  vrp_in_t    in_data = '0;
  logic       in_stall;
  logic       out_valid;
  vrp_out_t   out_data;
  logic       out_stall = 1'b0;

  projection_board board = new();
  bit  calm = 1'b0;  // true during the stretch with no idling
  int  cycles = 0;

  vertex_rotate_project_to_screen DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check output beats and pick the next stall; also enforce the timeout.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
    if (!rst) begin
      if (out_valid && !out_stall) board.check_beat(out_data);
      out_stall <= !calm && ($urandom_range(99) < 7);
    end
  end

  // Leave the enable high; the caller drops it after the last write.
  task automatic write_reg(vrp_reg_t idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    board.write_reg(idx, val);
  endtask

  // Hold the beat until accepted; note it in the same edge it is taken.
  task automatic send_vertex(vrp_in_t v);
    while (!calm && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_vertex(v);
  endtask

  // Wait for the unit to drain, then pad past the pipeline depth.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic vrp_in_t any_vertex(bit narrow);
    vrp_in_t v;
    v.vertex_x       = 16'($urandom);
    v.vertex_y       = 16'($urandom);
    v.vertex_z       = 16'($urandom);
    v.rotation_angle = 10'($urandom);
    if (narrow) begin
      // keep the vertex near the origin so the projection lands on screen
      v.vertex_x = $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
      v.vertex_y = $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
      v.vertex_z = $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
    end
    return v;
  endfunction

  task automatic directed_items();
    vrp_in_t v;
    int ext[4] = '{-32768, 32767, 0, -1};
    foreach (ext[i]) begin
      v.vertex_x = 16'(ext[i]);
      v.vertex_y = 16'(ext[(i + 1) % 4]);
      v.vertex_z = 16'(ext[(i + 2) % 4]);
      v.rotation_angle = (i == 0) ? 10'd0 : (i == 1) ? 10'd1023 : 10'(i * 256);
      send_vertex(v);
    end
    // eighth-turn angles and the zero depth case: z = -8192 at angle 0
    for (int a = 0; a < 1024; a += 128) begin
      v = '{16'sd4096, -16'sd4096, 16'sd2048, 10'(a)};
      send_vertex(v);
    end
    v = '{16'sd1000, 16'sd1000, -16'sd8192, 10'd0};
    send_vertex(v);
    v = '{16'sd0, 16'sd4096, 16'sd8192, 10'd512};  // rotated z cancels offset
    send_vertex(v);
    v = '{16'sd3000, 16'sd3000, -16'sd20000, 10'd0};  // behind the camera
    send_vertex(v);
  endtask

  initial begin
    vrp_in_t v;
    logic [15:0] offs[5] = '{16'h8000, 16'h7FFF, 16'h0000, 16'h2000, 16'h0001};
    board.reset_regs();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_items();
    drain();

    // Each phase: new register setting, then a batch of random vertices.
    for (int p = 0; p < 9; p++) begin
      write_reg(REG_DEPTH_OFFSET, (p < 5) ? offs[p] : 16'($urandom));
      write_reg(REG_PIXEL_SCALE, (p == 0) ? 16'd0 : (p == 1) ? 16'd255 : 16'($urandom));
      write_reg(REG_CENTER_X, (p == 0) ? 16'd0 : (p == 1) ? 16'd1023 : 16'($urandom));
      write_reg(REG_CENTER_Y, (p == 1) ? 16'd0 : (p == 0) ? 16'd1023 : 16'($urandom));
      cfg_we <= 1'b0;
      calm = (p == 4);
      for (int n = 0; n < 150; n++) begin
        v = any_vertex(1'($urandom_range(1)));
        // now and then aim for exact zero depth at angle zero
        if ($urandom_range(19) == 0) begin
          v.rotation_angle = '0;
          v.vertex_z = -board.depth_off;
        end
        send_vertex(v);
      end
      drain();
    end
    calm = 1'b0;

    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
